// File: rtl/core/sorted_priority_queue_defines.svh
// Assertion macros shared by the sorted priority queue RTL.
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SPQ_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/spq_pkg.sv
// Shared types and constants of the sorted priority queue.
package spq_pkg;

   localparam int DEF_QUEUE_DEPTH = 16;
   localparam int PRIO_W          = 16;
   localparam int HANDLE_W        = 16;
   localparam int ENTRY_W         = PRIO_W + HANDLE_W;
   localparam int COUNT_W         = 5;
   localparam int STATUS_W        = 2;
   localparam int REQ_DATA_W      = 32;
   localparam int RSP_DATA_W      = 40;

   // Request kinds.
   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_REMOVE = 1'b1;

   // Status codes.
   localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   // Completion of one request, from the sequencer to the output stage.
   typedef struct packed {
      logic                valid;
      logic [STATUS_W-1:0] status;
   } spq_done_type;

endpackage

// File: rtl/core/spq_store.sv
// Entry store: one write port and one registered read port.
module spq_store import spq_pkg::*; #(
   parameter int DEPTH = DEF_QUEUE_DEPTH,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  logic [ENTRY_W-1:0] wr_data,
   input  logic [AW-1:0]      rd_addr,
   output logic [ENTRY_W-1:0] rd_data
);

   logic [ENTRY_W-1:0] mem_ff [DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/spq_seq.sv
// Request sequencer: walks the store one entry per cycle with a shared comparator.
module spq_seq import spq_pkg::*; #(
   parameter int DEPTH = DEF_QUEUE_DEPTH,
   localparam int AW = $clog2(DEPTH),
   localparam int CW = $clog2(DEPTH + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_kind,
   input  logic [PRIO_W-1:0]   req_prio,
   input  logic [HANDLE_W-1:0] req_handle,
   output logic                mem_wr_en,
   output logic [AW-1:0]       mem_wr_addr,
   output logic [ENTRY_W-1:0]  mem_wr_data,
   output logic [AW-1:0]       mem_rd_addr,
   input  logic [ENTRY_W-1:0]  mem_rd_data,
   input  logic                out_free,
   output spq_done_type        done,
   output logic [ENTRY_W-1:0]  head_entry,
   output logic [CW-1:0]       count
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_INS  = 3'd1;
   localparam logic [2:0] S_PUT  = 3'd2;
   localparam logic [2:0] S_REM  = 3'd3;
   localparam logic [2:0] S_FIN  = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic [AW-1:0]       idx_ff, idx_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [ENTRY_W-1:0]  new_ff, new_in;
   logic [ENTRY_W-1:0]  head_ff, head_in;
   logic                rd_above;

   // Store entries hold the priority in the upper half.
   assign rd_above = mem_rd_data[ENTRY_W-1 -: PRIO_W] > new_ff[ENTRY_W-1 -: PRIO_W];

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      cnt_in      = cnt_ff;
      status_in   = status_ff;
      new_in      = new_ff;
      req_ready   = 1'b0;
      mem_wr_en   = 1'b0;
      mem_wr_addr = idx_ff;
      mem_wr_data = new_ff;
      mem_rd_addr = idx_ff;
      done.valid  = 1'b0;
      done.status = status_ff;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               new_in    = {req_prio, req_handle};
               status_in = ST_DONE;
               state_in  = S_FIN;
               if (req_kind == REQ_INSERT) begin
                  if (cnt_ff == CW'(DEPTH)) begin
                     status_in = ST_FULL;
                  end else if (cnt_ff == '0) begin
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = '0;
                     mem_wr_data = {req_prio, req_handle};
                     cnt_in      = cnt_ff + 1'b1;
                  end else begin
                     idx_in      = AW'(cnt_ff - 1'b1);
                     mem_rd_addr = AW'(cnt_ff - 1'b1);
                     cnt_in      = cnt_ff + 1'b1;
                     state_in    = S_INS;
                  end
               end else begin
                  if (cnt_ff == '0) begin
                     status_in = ST_EMPTY;
                  end else if (cnt_ff == CW'(1)) begin
                     cnt_in = '0;
                  end else begin
                     idx_in      = AW'(1);
                     mem_rd_addr = AW'(1);
                     cnt_in      = cnt_ff - 1'b1;
                     state_in    = S_REM;
                  end
               end
            end
         end
         S_INS: begin
            // Scan from the tail; each lower-or-equal entry moves down one slot.
            mem_wr_en   = 1'b1;
            mem_wr_addr = idx_ff + 1'b1;
            if (rd_above) begin
               mem_wr_data = new_ff;
               state_in    = S_FIN;
            end else begin
               mem_wr_data = mem_rd_data;
               if (idx_ff == '0) begin
                  state_in = S_PUT;
               end else begin
                  idx_in      = idx_ff - 1'b1;
                  mem_rd_addr = idx_ff - 1'b1;
               end
            end
         end
         S_PUT: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = '0;
            mem_wr_data = new_ff;
            state_in    = S_FIN;
         end
         S_REM: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = idx_ff - 1'b1;
            mem_wr_data = mem_rd_data;
            if (CW'(idx_ff) == cnt_ff) begin
               state_in = S_FIN;
            end else begin
               idx_in      = idx_ff + 1'b1;
               mem_rd_addr = idx_ff + 1'b1;
            end
         end
         S_FIN: begin
            done.valid = 1'b1;
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // The head slot is mirrored so the result needs no extra store read.
   assign head_in = (mem_wr_en && mem_wr_addr == '0) ? mem_wr_data : head_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      idx_ff    <= idx_in;
      status_ff <= status_in;
      new_ff    <= new_in;
      head_ff   <= head_in;
   end

   assign head_entry = head_ff;
   assign count      = cnt_ff;

endmodule

// File: rtl/core/sorted_priority_queue.sv
// A bounded priority queue kept in descending priority order in an entry store with one
// write port and one registered read port. Every request answers with one word giving the
// head entry, the empty flag, the entry count and a status. The block takes one request at
// a time. An insert into an empty queue writes the head slot directly, one refused as full
// writes nothing, and any other insert scans from the tail, moving each entry of lower or
// equal priority down one slot, then writes the new entry into the freed slot. A remove
// shifts each remaining entry up one slot unless it empties the queue or is refused. The
// store's single read port and the one priority comparator move or test one entry per
// cycle. The result word sits in an output register; a new request is taken while it
// waits.
`include "sorted_priority_queue_defines.svh"

module sorted_priority_queue import spq_pkg::*; #(
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // entry_priority [15:0], entry_handle [31:16]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // req_type [0]
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // head_handle [15:0], head_priority [31:16], is_empty [32],
   // entry_count [37:33], status [39:38]
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic                  mem_wr_en;
   logic [AW-1:0]         mem_wr_addr;
   logic [ENTRY_W-1:0]    mem_wr_data;
   logic [AW-1:0]         mem_rd_addr;
   logic [ENTRY_W-1:0]    mem_rd_data;
   logic                  out_free;
   spq_done_type          done;
   logic [ENTRY_W-1:0]    head_entry;
   logic [CW-1:0]         count;
   logic                  empty;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   spq_store #(.DEPTH(QUEUE_DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   spq_seq #(.DEPTH(QUEUE_DEPTH)) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_kind    (req_tuser),
      .req_prio    (req_tdata[PRIO_W-1:0]),
      .req_handle  (req_tdata[PRIO_W +: HANDLE_W]),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .out_free    (out_free),
      .done        (done),
      .head_entry  (head_entry),
      .count       (count)
   );

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign empty    = (count == '0);

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (done.valid && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {done.status,
                         COUNT_W'(count),
                         empty,
                         empty ? {PRIO_W{1'b0}} : head_entry[ENTRY_W-1 -: PRIO_W],
                         empty ? {HANDLE_W{1'b0}} : head_entry[HANDLE_W-1:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `SPQ_ASSERT_NOW(a_count_bound, 1'b1, count <= CW'(QUEUE_DEPTH), "entry count above depth")
   `SPQ_ASSERT_NEXT(a_busy_after_accept, req_tvalid && req_tready, !req_tready, "request taken while busy")
   `SPQ_ASSERT_NOW(a_refused_empty, rsp_tvalid && rsp_tdata[39:38] == ST_EMPTY, rsp_tdata[32], "empty refusal on a filled queue")
   `SPQ_ASSERT_NOW(a_empty_flag, rsp_tvalid, rsp_tdata[32] == (rsp_tdata[37:33] == '0) || QUEUE_DEPTH > 31, "empty flag disagrees with count")

endmodule

// File: sim/sorted_priority_queue_tb.sv
// Self-checking testbench for the sorted priority queue: random and directed requests.
`timescale 1ns / 100ps

module sorted_priority_queue_tb;
   import spq_pkg::*;

   localparam int DEPTH       = DEF_QUEUE_DEPTH;
   localparam int CYCLE_LIMIT = 500000;
   localparam int RANDOM_ITEMS = 1000;
   localparam int IDLE_PCT    = 23;
   localparam int HOLD_CYCLES = 300;

   typedef struct packed {
      logic [PRIO_W-1:0]   prio;
      logic [HANDLE_W-1:0] handle;
   } queue_entry_type;

   // Result word layout, most significant field first.
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  count;
      logic                is_empty;
      logic [PRIO_W-1:0]   head_prio;
      logic [HANDLE_W-1:0] head_handle;
   } head_report_type;

   class queue_scoreboard;
      queue_entry_type entries[$];
      head_report_type expected_reports[$];
      int errors;
      int inserts;
      int removes;
      int full_refusals;
      int empty_refusals;
      int peak;
      int checked;

      function void note_request(logic kind, logic [PRIO_W-1:0] prio,
                                 logic [HANDLE_W-1:0] hnd);
         head_report_type rpt;
         queue_entry_type e;
         int pos;
         rpt.status = ST_DONE;
         if (kind == REQ_INSERT) begin
            inserts++;
            if (entries.size() >= DEPTH) begin
               rpt.status = ST_FULL;
               full_refusals++;
            end else begin
               // The new entry goes ahead of every entry with priority <= its own.
               pos = 0;
               while (pos < entries.size() && entries[pos].prio > prio)
                  pos++;
               e.prio = prio;
               e.handle = hnd;
               entries.insert(pos, e);
            end
         end else begin
            removes++;
            if (entries.size() == 0) begin
               rpt.status = ST_EMPTY;
               empty_refusals++;
            end else begin
               entries.delete(0);
            end
         end
         if (entries.size() > peak)
            peak = entries.size();
         if (entries.size() == 0) begin
            rpt.head_handle = '0;
            rpt.head_prio = '0;
            rpt.is_empty = 1'b1;
         end else begin
            rpt.head_handle = entries[0].handle;
            rpt.head_prio = entries[0].prio;
            rpt.is_empty = 1'b0;
         end
         rpt.count = COUNT_W'(entries.size());
         expected_reports.push_back(rpt);
      endfunction

      function void check_report(logic [RSP_DATA_W-1:0] word);
         head_report_type act;
         head_report_type exp_rpt;
         act = word;
         checked++;
         if (expected_reports.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("ERROR: unexpected result word %h", word);
            return;
         end
         exp_rpt = expected_reports.pop_front();
         if (act.head_handle !== exp_rpt.head_handle || act.head_prio !== exp_rpt.head_prio ||
             act.is_empty !== exp_rpt.is_empty || act.count !== exp_rpt.count ||
             act.status !== exp_rpt.status) begin
            errors++;
            if (errors <= 10) begin
               $display("ERROR: word %0d expected handle %h prio %h empty %b count %0d status %0d",
                        checked, exp_rpt.head_handle, exp_rpt.head_prio, exp_rpt.is_empty,
                        exp_rpt.count, exp_rpt.status);
               $display("       got handle %h prio %h empty %b count %0d status %0d",
                        act.head_handle, act.head_prio, act.is_empty, act.count, act.status);
            end
         end
      endfunction

      function int pending();
         return expected_reports.size();
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   queue_scoreboard sb = new();
   bit steady;
   bit hold_request;
   bit hold_off;
   int cycle_count;

   sorted_priority_queue DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding",
                  cycle_count, sb.pending());
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Both channels are sampled at the rising edge; inputs only move at the falling edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            sb.check_report(rsp_tdata);
         if (req_tvalid && req_tready)
            sb.note_request(req_tuser, req_tdata[PRIO_W-1:0],
                            req_tdata[PRIO_W+HANDLE_W-1:PRIO_W]);
      end
   end

   // Receiver: random stalls, none during the steady stretch, all during the hold-off.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off)
            rsp_tready <= 1'b0;
         else if (steady)
            rsp_tready <= 1'b1;
         else
            rsp_tready <= ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // Long hold-off on the result side while requests keep coming.
   initial begin
      hold_off = 1'b0;
      wait (hold_request);
      @(posedge clock);
      hold_off = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off = 1'b0;
   end

   // Called at a falling edge; returns at the falling edge after the word is taken.
   task automatic send_request(input logic kind, input logic [PRIO_W-1:0] prio,
                               input logic [HANDLE_W-1:0] hnd);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {hnd, prio};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   function automatic logic [PRIO_W-1:0] pick_priority();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         2, 3, 4, 5: return PRIO_W'($urandom_range(7)) << 8;  // narrow set for ties
         default: return PRIO_W'($urandom);
      endcase
   endfunction

   task automatic run_directed();
      int i;
      send_request(REQ_REMOVE, 16'h0000, 16'h0000);
      send_request(REQ_INSERT, 16'hFFFF, 16'hFFFF);
      send_request(REQ_INSERT, 16'h0000, 16'h0000);
      send_request(REQ_INSERT, 16'h8000, 16'h0001);
      // Equal priorities: the newest entry must come out first.
      send_request(REQ_INSERT, 16'h8000, 16'h0002);
      send_request(REQ_INSERT, 16'hFFFF, 16'h1234);
      send_request(REQ_REMOVE, 16'h0000, 16'h0000);
      send_request(REQ_INSERT, 16'h0000, 16'hAAAA);
      for (i = 0; i < 10; i++)
         send_request(REQ_INSERT, PRIO_W'(i * 16'h1111), 16'h5555 ^ HANDLE_W'(i));
      send_request(REQ_INSERT, 16'hFFFF, 16'hBEEF);
      send_request(REQ_REMOVE, 16'h0000, 16'h0000);
      send_request(REQ_REMOVE, 16'h0000, 16'h0000);
   endtask

   task automatic run_random();
      int n;
      int phase_left;
      int insert_pct;
      logic kind;
      phase_left = 0;
      insert_pct = 50;
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         steady = (n >= 200 && n < 350);
         if (n == 600)
            hold_request = 1'b1;
         // Phases lean toward filling, draining or balance, so full and empty come often.
         if (phase_left == 0) begin
            phase_left = $urandom_range(20, 80);
            case ($urandom_range(2))
               0: insert_pct = 85;
               1: insert_pct = 15;
               default: insert_pct = 50;
            endcase
         end
         phase_left--;
         kind = ($urandom_range(99) < insert_pct) ? REQ_INSERT : REQ_REMOVE;
         send_request(kind, pick_priority(), HANDLE_W'($urandom));
      end
      steady = 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = REQ_INSERT;
      steady = 1'b0;
      hold_request = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      run_directed();
      run_random();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
      // Allow well past the longest request, which walks the whole store.
      repeat (4 * DEPTH + 20) @(posedge clock);
      if (sb.pending() != 0) begin
         sb.errors++;
         $display("ERROR: %0d expected results never arrived", sb.pending());
      end
      $display("Covered %0d inserts (%0d refused as full) and %0d removes (%0d refused as empty).",
               sb.inserts, sb.full_refusals, sb.removes, sb.empty_refusals);
      $display("Checked %0d result words, peak occupancy %0d of %0d, %0d mismatches.",
               sb.checked, sb.peak, DEPTH, sb.errors);
      if (sb.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// File: sorted_priority_queue.f
+incdir+rtl/core
rtl/core/spq_pkg.sv
rtl/core/spq_store.sv
rtl/core/spq_seq.sv
rtl/core/sorted_priority_queue.sv
sim/sorted_priority_queue_tb.sv
